// ----- src/dual_wheel_pid_speed_control_top_macros.svh -----
// Assertion macros for the dual wheel PID speed controller checker.
// Clocked on clock, disabled while reset is high.
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_TOP_MACROS_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_TOP_MACROS_SVH

// same-cycle implication
`define DWPID_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DWPID_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/dwpid_pkg.sv -----
// Shared types and constants for the dual wheel PID speed controller.
// No dependencies.
package dwpid_pkg;

   localparam int SPEED_W = 16;
   localparam int GAIN_W  = 24;
   localparam int ERR_W   = 17;
   localparam int INTEG_W = 32;
   localparam int DRIVE_W = 8;
   localparam int DUTY_W  = 7;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_REF  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_REF   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd4;

   localparam logic signed [SPEED_W-1:0] REF_RESET        = 16'sd800;
   localparam logic [GAIN_W-1:0]         PROP_GAIN_RESET  = 24'd3355;
   localparam logic [GAIN_W-1:0]         INTEG_GAIN_RESET = 24'd524288;
   localparam logic [GAIN_W-1:0]         DERIV_GAIN_RESET = 24'd12583;

   localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 8'sd90;
   // 90 in Q.26 and Q.24
   localparam logic signed [45:0] DRIVE_LIM_Q26 = 46'sd6039797760;
   localparam logic signed [INTEG_W-1:0] INTEG_LIM_Q24 = 32'sd1509949440;

   typedef struct packed {
      logic signed [ERR_W-1:0]   last_err;
      logic signed [INTEG_W-1:0] integ;
   } wheel_state_type;

endpackage

// ----- src/dwpid_wheel.sv -----
// One wheel of the PID law: error, P/I/D terms, drive saturation, integral clamp.
// Depends on dwpid_pkg.
module dwpid_wheel (
   input  logic signed [dwpid_pkg::SPEED_W-1:0] reference,
   input  logic signed [dwpid_pkg::SPEED_W-1:0] speed,
   input  logic                                 restart,
   input  logic [dwpid_pkg::GAIN_W-1:0]         kp,
   input  logic [dwpid_pkg::GAIN_W-1:0]         ki,
   input  logic [dwpid_pkg::GAIN_W-1:0]         kd,
   input  dwpid_pkg::wheel_state_type           state_cur,
   output dwpid_pkg::wheel_state_type           state_nxt,
   output logic signed [dwpid_pkg::DRIVE_W-1:0] drive
);
   import dwpid_pkg::*;

   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W-1:0]   last_err;
   logic signed [INTEG_W-1:0] integ;
   logic signed [ERR_W:0]     err_sum;
   logic signed [ERR_W:0]     err_diff;
   logic signed [41:0]        p_term;
   logic signed [42:0]        i_prod;
   logic signed [42:0]        d_term;
   logic signed [40:0]        i_inc;
   logic signed [41:0]        i_new;
   logic signed [45:0]        sum;
   logic signed [45:0]        sum_adj;

   always_comb begin
      err      = {reference[SPEED_W-1], reference} - {speed[SPEED_W-1], speed};
      last_err = restart ? err : state_cur.last_err;
      integ    = restart ? '0 : state_cur.integ;
      err_sum  = {err[ERR_W-1], err} + {last_err[ERR_W-1], last_err};
      err_diff = {err[ERR_W-1], err} - {last_err[ERR_W-1], last_err};

      p_term = $signed({1'b0, kp}) * err;
      i_prod = $signed({1'b0, ki}) * err_sum;
      d_term = $signed({1'b0, kd}) * err_diff;

      // floor to Q.24
      i_inc = 41'(i_prod >>> 2);
      i_new = 42'(integ) + 42'(i_inc);
      sum   = 46'(p_term) + (46'(i_new) <<< 2) + 46'(d_term);

      // truncate toward zero
      sum_adj = sum + (sum[45] ? 46'sd67108863 : 46'sd0);
      if (sum >= DRIVE_LIM_Q26) begin
         drive = DRIVE_LIMIT;
      end else if (sum <= -DRIVE_LIM_Q26) begin
         drive = -DRIVE_LIMIT;
      end else begin
         drive = sum_adj[33:26];
      end

      state_nxt.last_err = err;
      if (i_new >= 42'(INTEG_LIM_Q24)) begin
         state_nxt.integ = INTEG_LIM_Q24;
      end else if (i_new <= -42'(INTEG_LIM_Q24)) begin
         state_nxt.integ = -INTEG_LIM_Q24;
      end else begin
         state_nxt.integ = i_new[INTEG_W-1:0];
      end
   end

endmodule

// ----- src/dual_wheel_pid_speed_control_top.sv -----
// rsp_valid rises once a request has passed the input register and the result register.
// One request per cycle unless rsp_stall holds; the PID state loop is unpipelined.
// Both wheels are computed in parallel by dwpid_wheel between the two registers.
// Reset (synchronous, active high) loads register defaults, clears the integrals and
// last errors, sets direction forward and forces a controller restart on the next request.
module dual_wheel_pid_speed_control_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [dwpid_pkg::SPEED_W-1:0] req_right_speed,
   input  logic signed [dwpid_pkg::SPEED_W-1:0] req_left_speed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dwpid_pkg::DRIVE_W-1:0] rsp_right_drive,
   output logic signed [dwpid_pkg::DRIVE_W-1:0] rsp_left_drive,
   output logic [dwpid_pkg::DUTY_W-1:0]         rsp_right_duty,
   output logic                                 rsp_right_reverse,
   output logic [dwpid_pkg::DUTY_W-1:0]         rsp_left_duty,
   output logic                                 rsp_left_reverse,
   input  logic                                 csr_wr_en,
   input  logic [dwpid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dwpid_pkg::GAIN_W-1:0]         csr_wdata
);
   import dwpid_pkg::*;

   logic signed [SPEED_W-1:0] right_ref_ff, left_ref_ff;
   logic [GAIN_W-1:0]         kp_ff, ki_ff, kd_ff;
   logic                      gains_changed_ff, gains_changed_in;

   logic                      in_vld_ff;
   logic signed [SPEED_W-1:0] in_right_speed_ff, in_left_speed_ff;

   wheel_state_type           right_state_ff, left_state_ff;
   wheel_state_type           right_state_in, left_state_in;
   logic                      right_dir_ff, left_dir_ff;
   logic                      right_dir_in, left_dir_in;

   logic                      out_vld_ff;
   logic signed [DRIVE_W-1:0] right_drive_ff, left_drive_ff;
   logic signed [DRIVE_W-1:0] right_drive_in, left_drive_in;
   logic [DUTY_W-1:0]         right_duty_ff, left_duty_ff;
   logic [DUTY_W-1:0]         right_duty_in, left_duty_in;

   logic advance;
   logic accept;
   logic step;

   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign step      = in_vld_ff && advance;

   dwpid_wheel u_right (
      .reference (right_ref_ff),
      .speed     (in_right_speed_ff),
      .restart   (gains_changed_ff),
      .kp        (kp_ff),
      .ki        (ki_ff),
      .kd        (kd_ff),
      .state_cur (right_state_ff),
      .state_nxt (right_state_in),
      .drive     (right_drive_in)
   );

   dwpid_wheel u_left (
      .reference (left_ref_ff),
      .speed     (in_left_speed_ff),
      .restart   (gains_changed_ff),
      .kp        (kp_ff),
      .ki        (ki_ff),
      .kd        (kd_ff),
      .state_cur (left_state_ff),
      .state_nxt (left_state_in),
      .drive     (left_drive_in)
   );

   always_comb begin
      right_duty_in = right_drive_in[DRIVE_W-1] ? DUTY_W'(-right_drive_in)
                                                : DUTY_W'(right_drive_in);
      left_duty_in  = left_drive_in[DRIVE_W-1]  ? DUTY_W'(-left_drive_in)
                                                : DUTY_W'(left_drive_in);
      // direction held while drive is zero
      right_dir_in = (right_drive_in == '0) ? right_dir_ff : right_drive_in[DRIVE_W-1];
      left_dir_in  = (left_drive_in == '0)  ? left_dir_ff  : left_drive_in[DRIVE_W-1];

      gains_changed_in = gains_changed_ff;
      if (step) begin
         gains_changed_in = 1'b0;
      end
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN, CSR_INTEG_GAIN, CSR_DERIV_GAIN: begin
               gains_changed_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ref_ff     <= REF_RESET;
         left_ref_ff      <= REF_RESET;
         kp_ff            <= PROP_GAIN_RESET;
         ki_ff            <= INTEG_GAIN_RESET;
         kd_ff            <= DERIV_GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RIGHT_REF:  right_ref_ff <= csr_wdata[SPEED_W-1:0];
            CSR_LEFT_REF:   left_ref_ff  <= csr_wdata[SPEED_W-1:0];
            CSR_PROP_GAIN:  kp_ff        <= csr_wdata;
            CSR_INTEG_GAIN: ki_ff        <= csr_wdata;
            CSR_DERIV_GAIN: kd_ff        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_changed_ff <= 1'b1;
         in_vld_ff        <= 1'b0;
         out_vld_ff       <= 1'b0;
         right_state_ff   <= '0;
         left_state_ff    <= '0;
         right_dir_ff     <= 1'b0;
         left_dir_ff      <= 1'b0;
      end else begin
         gains_changed_ff <= gains_changed_in;
         in_vld_ff        <= accept || (in_vld_ff && !advance);
         if (advance) begin
            out_vld_ff <= in_vld_ff;
         end
         if (step) begin
            right_state_ff <= right_state_in;
            left_state_ff  <= left_state_in;
            right_dir_ff   <= right_dir_in;
            left_dir_ff    <= left_dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_right_speed_ff <= req_right_speed;
         in_left_speed_ff  <= req_left_speed;
      end
      if (step) begin
         right_drive_ff <= right_drive_in;
         left_drive_ff  <= left_drive_in;
         right_duty_ff  <= right_duty_in;
         left_duty_ff   <= left_duty_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_right_drive   = right_drive_ff;
   assign rsp_left_drive    = left_drive_ff;
   assign rsp_right_duty    = right_duty_ff;
   assign rsp_left_duty     = left_duty_ff;
   assign rsp_right_reverse = right_dir_ff;
   assign rsp_left_reverse  = left_dir_ff;

endmodule

// ----- src/dwpid_checker.sv -----
// Port-level checker for dual_wheel_pid_speed_control_top, bound to the top level.
// Depends on dual_wheel_pid_speed_control_top_macros.svh.
`include "dual_wheel_pid_speed_control_top_macros.svh"

module dwpid_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [7:0] rsp_right_drive,
   input logic signed [7:0] rsp_left_drive,
   input logic [6:0]        rsp_right_duty,
   input logic              rsp_right_reverse,
   input logic [6:0]        rsp_left_duty,
   input logic              rsp_left_reverse
);

   `DWPID_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_right_drive) && $stable(rsp_left_drive), "stalled result changed")
   `DWPID_ASSERT_IMPL(a_drive_range, rsp_valid, rsp_right_drive <= 8'sd90 && rsp_right_drive >= -8'sd90 && rsp_left_drive <= 8'sd90 && rsp_left_drive >= -8'sd90, "drive out of range")
   `DWPID_ASSERT_IMPL(a_duty_mag, rsp_valid, rsp_right_duty == 7'(rsp_right_drive[7] ? -rsp_right_drive : rsp_right_drive) && rsp_left_duty == 7'(rsp_left_drive[7] ? -rsp_left_drive : rsp_left_drive), "duty is not drive magnitude")
   `DWPID_ASSERT_IMPL(a_reverse_sign, rsp_valid && rsp_right_drive != 8'sd0, rsp_right_reverse == rsp_right_drive[7], "right reverse disagrees with drive sign")
   `DWPID_ASSERT_IMPL(a_reverse_sign_l, rsp_valid && rsp_left_drive != 8'sd0, rsp_left_reverse == rsp_left_drive[7], "left reverse disagrees with drive sign")

endmodule

bind dual_wheel_pid_speed_control_top dwpid_checker u_dwpid_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_right_drive   (rsp_right_drive),
   .rsp_left_drive    (rsp_left_drive),
   .rsp_right_duty    (rsp_right_duty),
   .rsp_right_reverse (rsp_right_reverse),
   .rsp_left_duty     (rsp_left_duty),
   .rsp_left_reverse  (rsp_left_reverse)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for dual_wheel_pid_speed_control_top: random and directed wheel speed
// requests, a per-wheel PID predictor and an in-order drive scoreboard. Needs dwpid_pkg.
module testbench;
   import dwpid_pkg::*;

   typedef struct {
      logic signed [SPEED_W-1:0] right_speed;
      logic signed [SPEED_W-1:0] left_speed;
   } wheel_speeds_t;

   typedef struct {
      logic signed [DRIVE_W-1:0] right_drive;
      logic signed [DRIVE_W-1:0] left_drive;
      logic [DUTY_W-1:0]         right_duty;
      logic                      right_reverse;
      logic [DUTY_W-1:0]         left_duty;
      logic                      left_reverse;
   } drive_result_t;

   localparam longint Q24_ONE    = 64'sd16777216;
   localparam longint Q26_ONE    = 64'sd67108864;
   localparam int     HOLD_AT    = 200;
   localparam int     HOLD_LEN   = 150;
   localparam int     IDLE_LIMIT = 3000;
   localparam int     MAX_PRINTS = 60;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SPEED_W-1:0]     req_right_speed = '0;
   logic signed [SPEED_W-1:0]     req_left_speed = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [DRIVE_W-1:0]     rsp_right_drive;
   logic signed [DRIVE_W-1:0]     rsp_left_drive;
   logic [DUTY_W-1:0]             rsp_right_duty;
   logic                          rsp_right_reverse;
   logic [DUTY_W-1:0]             rsp_left_duty;
   logic                          rsp_left_reverse;
   logic                          csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [GAIN_W-1:0]             csr_wdata = '0;

   // predictor copy of registers and controller state
   logic signed [SPEED_W-1:0] target_speed [2] = '{REF_RESET, REF_RESET};
   logic [GAIN_W-1:0]         kp_gain = PROP_GAIN_RESET;
   logic [GAIN_W-1:0]         ki_gain = INTEG_GAIN_RESET;
   logic [GAIN_W-1:0]         kd_gain = DERIV_GAIN_RESET;
   longint                    wheel_last_err [2] = '{0, 0};
   longint                    wheel_integ [2] = '{0, 0};
   logic                      wheel_reverse [2] = '{1'b0, 1'b0};
   logic                      restart_pending = 1'b1;

   wheel_speeds_t speed_queue [$];
   drive_result_t drive_expected [$];
   wheel_speeds_t offered;
   drive_result_t want;
   int            mismatches = 0;
   int            results_seen = 0;
   int            send_gap = 0;
   int            stall_left = 0;
   int            quiet_cycles = 0;
   bit            no_idle = 1'b0;

   dual_wheel_pid_speed_control_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_right_speed(req_right_speed),
      .req_left_speed(req_left_speed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_right_drive(rsp_right_drive),
      .rsp_left_drive(rsp_left_drive),
      .rsp_right_duty(rsp_right_duty),
      .rsp_right_reverse(rsp_right_reverse),
      .rsp_left_duty(rsp_left_duty),
      .rsp_left_reverse(rsp_left_reverse),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one wheel of the PID law; returns the saturated drive
   function automatic longint wheel_law(input int w, input longint err, input bit restart);
      longint kp, ki, kd, inc, i_new, sum, drive;
      kp = longint'(kp_gain);
      ki = longint'(ki_gain);
      kd = longint'(kd_gain);
      if (restart) begin
         wheel_integ[w] = 0;
         wheel_last_err[w] = err;
      end
      inc = (ki * (err + wheel_last_err[w])) >>> 2;
      i_new = wheel_integ[w] + inc;
      sum = kp * err + i_new * 4 + kd * (err - wheel_last_err[w]);
      if (sum >= 90 * Q26_ONE) begin
         drive = 90;
      end else if (sum <= -90 * Q26_ONE) begin
         drive = -90;
      end else begin
         drive = sum / Q26_ONE;
      end
      if (i_new >= 90 * Q24_ONE) begin
         i_new = 90 * Q24_ONE;
      end else if (i_new <= -90 * Q24_ONE) begin
         i_new = -90 * Q24_ONE;
      end
      wheel_integ[w] = i_new;
      wheel_last_err[w] = err;
      return drive;
   endfunction

   function automatic drive_result_t compute_drive(input wheel_speeds_t s);
      drive_result_t r;
      longint        drv [2];
      logic [DUTY_W-1:0] duty [2];
      drv[0] = wheel_law(0, longint'(target_speed[0]) - longint'(s.right_speed),
                         restart_pending);
      drv[1] = wheel_law(1, longint'(target_speed[1]) - longint'(s.left_speed),
                         restart_pending);
      restart_pending = 1'b0;
      for (int w = 0; w < 2; w++) begin
         if (drv[w] > 0) begin
            wheel_reverse[w] = 1'b0;
         end else if (drv[w] < 0) begin
            wheel_reverse[w] = 1'b1;
         end
         duty[w] = DUTY_W'(drv[w] < 0 ? -drv[w] : drv[w]);
      end
      r.right_drive   = DRIVE_W'(drv[0]);
      r.left_drive    = DRIVE_W'(drv[1]);
      r.right_duty    = duty[0];
      r.right_reverse = wheel_reverse[0];
      r.left_duty     = duty[1];
      r.left_reverse  = wheel_reverse[1];
      return r;
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input longint got, input longint exp_v);
      if (got != exp_v) begin
         report($sformatf("result %0d %s: got %0d, expected %0d",
                          results_seen, name, got, exp_v));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            drive_expected.push_back(compute_drive(offered));
            send_gap = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (req_valid && req_stall) begin
            // hold the stalled request
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (speed_queue.size() > 0) begin
            offered = speed_queue.pop_front();
            req_right_speed <= offered.right_speed;
            req_left_speed <= offered.left_speed;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (drive_expected.size() == 0) begin
               report($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = drive_expected.pop_front();
               check_field("right_drive", rsp_right_drive, want.right_drive);
               check_field("left_drive", rsp_left_drive, want.left_drive);
               check_field("right_duty", rsp_right_duty, want.right_duty);
               check_field("right_reverse", rsp_right_reverse, want.right_reverse);
               check_field("left_duty", rsp_left_duty, want.left_duty);
               check_field("left_reverse", rsp_left_reverse, want.left_reverse);
            end
            if (results_seen == HOLD_AT) begin
               stall_left = HOLD_LEN;
            end else begin
               stall_left = no_idle ? 0 : $urandom_range(0, 5);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_RIGHT_REF: target_speed[0] = data[SPEED_W-1:0];
         CSR_LEFT_REF: target_speed[1] = data[SPEED_W-1:0];
         CSR_PROP_GAIN: begin
            kp_gain = data;
            restart_pending = 1'b1;
         end
         CSR_INTEG_GAIN: begin
            ki_gain = data;
            restart_pending = 1'b1;
         end
         CSR_DERIV_GAIN: begin
            kd_gain = data;
            restart_pending = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (speed_queue.size() != 0 || req_valid || drive_expected.size() != 0);
      @(posedge clock);
   endtask

   task automatic push_speeds(input logic signed [SPEED_W-1:0] r, input logic signed [SPEED_W-1:0] l);
      wheel_speeds_t s;
      s.right_speed = r;
      s.left_speed = l;
      speed_queue.push_back(s);
   endtask

   function automatic logic signed [SPEED_W-1:0] speed_near(input logic signed [SPEED_W-1:0] t);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         return SPEED_W'(int'(t) + int'($urandom_range(0, 4000)) - 2000);
      end else if (pick <= 7) begin
         return SPEED_W'($urandom);
      end else if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return t;
   endfunction

   task automatic run_batch(input int n);
      for (int i = 0; i < n; i++) begin
         push_speeds(speed_near(target_speed[0]), speed_near(target_speed[1]));
      end
      wait_idle();
   endtask

   function automatic logic [GAIN_W-1:0] random_gain();
      case ($urandom_range(0, 3))
         0: return GAIN_W'($urandom_range(0, 1 << 14));
         1: return GAIN_W'($urandom_range(0, 1 << 20));
         2: return GAIN_W'($urandom);
         default: return GAIN_W'($urandom_range(0, 1 << 17));
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: restart after reset, zero error, field extremes
      push_speeds(16'sd800, 16'sd800);
      push_speeds(16'sh8000, 16'sh7FFF);
      push_speeds(16'sh7FFF, 16'sh8000);
      push_speeds(16'sd0, 16'sd0);
      push_speeds(-16'sd1, -16'sd1);
      push_speeds(16'sh7FFF, 16'sh7FFF);
      push_speeds(16'sh8000, 16'sh8000);
      push_speeds(16'sd799, 16'sd801);
      push_speeds(16'sd801, 16'sd799);
      push_speeds(16'sh5555, 16'shAAAA);
      push_speeds(16'shAAAA, 16'sh5555);
      push_speeds(16'sd800, 16'sd800);
      push_speeds(16'sd800, 16'sd800);
      push_speeds(16'sd1600, 16'sd0);
      wait_idle();

      // reference extremes, no restart
      no_idle = 1'b1;
      write_register(CSR_RIGHT_REF, 24'h007FFF);
      write_register(CSR_LEFT_REF, 24'h008000);
      csr_wr_en <= 1'b0;
      run_batch(40);
      no_idle = 1'b0;

      // gains at maximum
      write_register(CSR_RIGHT_REF, 24'h000000);
      write_register(CSR_LEFT_REF, 24'h000000);
      write_register(CSR_PROP_GAIN, 24'hFFFFFF);
      write_register(CSR_INTEG_GAIN, 24'hFFFFFF);
      write_register(CSR_DERIV_GAIN, 24'hFFFFFF);
      csr_wr_en <= 1'b0;
      run_batch(40);

      // gains at zero: drive stays zero, direction held
      write_register(CSR_PROP_GAIN, 24'h000000);
      write_register(CSR_INTEG_GAIN, 24'h000000);
      write_register(CSR_DERIV_GAIN, 24'h000000);
      csr_wr_en <= 1'b0;
      run_batch(30);

      // unused indexes ignored, extra bits masked, rewrite of same gain restarts
      for (int i = int'(CSR_DERIV_GAIN) + 1; i < (1 << CSR_IDX_W); i++) begin
         write_register(CSR_IDX_W'(i), GAIN_W'($urandom));
      end
      write_register(CSR_RIGHT_REF, 24'hA50320);
      write_register(CSR_LEFT_REF, 24'h5AFCE0);
      write_register(CSR_INTEG_GAIN, 24'h020000);
      write_register(CSR_PROP_GAIN, 24'h000D1B);
      write_register(CSR_DERIV_GAIN, 24'h003127);
      write_register(CSR_PROP_GAIN, 24'h000D1B);
      csr_wr_en <= 1'b0;
      run_batch(30);

      for (int phase = 0; phase < 7; phase++) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            write_register(CSR_RIGHT_REF, GAIN_W'($urandom_range(0, 6400)) - 24'd3200);
         end
         if ($urandom_range(0, 9) < 7) begin
            write_register(CSR_LEFT_REF, GAIN_W'($urandom));
         end
         if ($urandom_range(0, 9) < 6) begin
            write_register(CSR_PROP_GAIN, random_gain());
         end
         if ($urandom_range(0, 9) < 6) begin
            write_register(CSR_INTEG_GAIN, random_gain());
         end
         if ($urandom_range(0, 9) < 6) begin
            write_register(CSR_DERIV_GAIN, random_gain());
         end
         csr_wr_en <= 1'b0;
         run_batch(40);
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && drive_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
